// File: rtl/core/pps_pkg.sv
package pps_pkg;

	localparam int REQ_TYPE_WIDTH  = 2;
	localparam int DIR_WIDTH       = 16;
	localparam int DIR_FRAC        = 14;
	localparam int SCALE_WIDTH     = 16;
	localparam int PIXEL_WIDTH     = 16;
	localparam int QUOT_WIDTH      = 13;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [REQ_TYPE_WIDTH-1:0] REQ_RADIUS = 2'd0;
	localparam logic [REQ_TYPE_WIDTH-1:0] REQ_SPHERE = 2'd1;
	localparam logic [REQ_TYPE_WIDTH-1:0] REQ_BOX    = 2'd2;
	localparam logic [REQ_TYPE_WIDTH-1:0] REQ_UNUSED = 2'd3;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_POS_X = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_POS_Y = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_POS_Z = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_DIR_X = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_DIR_Y = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAM_DIR_Z = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VIEW_H    = 3'd6;

	localparam logic signed [DIR_WIDTH-1:0] DIR_Z_RESET = 16'sd16384;

	typedef struct packed {
		logic [PIXEL_WIDTH-1:0] size_px;
		logic                   culled;
	} pps_result_t;

endpackage

// File: rtl/core/pps_sqrt.sv
module pps_sqrt
	import pps_pkg::*;
#(
	parameter int N  = 26,
	parameter int SW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SW-1:0]    in_side,
	input  logic [2*N-1:0]   radicand,
	output logic             out_valid,
	output logic [SW-1:0]    out_side,
	output logic [N-1:0]     root
);

	localparam int RW2 = 2 * N;

	logic [RW2-1:0] op_s   [N];
	logic [RW2-1:0] res_s  [N];
	logic [SW-1:0]  side_s [N];
	logic [N-1:0]   vld_s;

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic [RW2-1:0] ONE = {{(RW2-1){1'b0}}, 1'b1} << (2 * (N - 1 - i));
		logic [RW2-1:0] op_in;
		logic [RW2-1:0] res_in;
		logic [RW2-1:0] trial;
		logic [SW-1:0]  side_in;
		logic           v_in;

		if (i == 0) begin : g_first
			assign op_in   = radicand;
			assign res_in  = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign op_in   = op_s[i-1];
			assign res_in  = res_s[i-1];
			assign side_in = side_s[i-1];
			assign v_in    = vld_s[i-1];
		end

		assign trial = res_in + ONE;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (op_in >= trial) begin
					op_s[i]  <= op_in - trial;
					res_s[i] <= (res_in >> 1) + ONE;
				end else begin
					op_s[i]  <= op_in;
					res_s[i] <= res_in >> 1;
				end
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_side  = side_s[N-1];
	assign root      = res_s[N-1][N-1:0];

endmodule

// File: rtl/core/pps_div.sv
module pps_div
	import pps_pkg::*;
#(
	parameter int NW = 41,
	parameter int DW = 30,
	parameter int QW = 13,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [SW-1:0] in_side,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          out_valid,
	output logic [SW-1:0] out_side,
	output logic [QW-1:0] quot
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [CW-1:0]  rem_s  [QW];
	logic [DW-1:0]  den_s  [QW];
	logic [QW-1:0]  q_s    [QW];
	logic [SW-1:0]  side_s [QW];
	logic [QW-1:0]  vld_s;

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [CW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] q_in;
		logic [SW-1:0] side_in;
		logic          v_in;
		logic [CW-1:0] shifted;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in  = CW'(num);
			assign den_in  = den;
			assign q_in    = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rem_in  = rem_s[i-1];
			assign den_in  = den_s[i-1];
			assign q_in    = q_s[i-1];
			assign side_in = side_s[i-1];
			assign v_in    = vld_s[i-1];
		end

		assign shifted = CW'(den_in) << (QW - 1 - i);
		assign ge      = rem_in >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? rem_in - shifted : rem_in;
				den_s[i]  <= den_in;
				q_s[i]    <= {q_in[QW-2:0], ge};
				side_s[i] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_side  = side_s[QW-1];
	assign quot      = q_s[QW-1];

endmodule

// File: rtl/core/pps_outbuf.sv
module pps_outbuf
	import pps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pps_result_t push_data,
	output logic        full,
	output logic        out_valid,
	input  logic        out_stall,
	output pps_result_t out_data
);

	pps_result_t slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  count_q;
	logic        pop;

	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign out_data  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("request pushed into full output buffer");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("output buffer count out of range");

endmodule

// File: rtl/core/projected_pixel_size_core.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | req_type, point_a_*, point_b_*,
//         |           |                       | obj_radius, obj_distance
// out     | output    | out_valid / out_stall | size_px, culled
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle while the output buffer is not full; requests pass the square root
// (one root bit per stage) and the divider (one quotient bit per stage).
// Reset clears all valid bits and loads the camera registers with their reset values.
// A two-entry output buffer takes results; the pipeline freezes only while it is full,
// so a request is taken while one result waits. cfg_ready is always high.
module projected_pixel_size_core
	import pps_pkg::*;
#(
	parameter int COORD_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
	input  logic [COORD_WIDTH-1:0]            cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [REQ_TYPE_WIDTH-1:0]         req_type,
	input  logic signed [COORD_WIDTH-1:0]     point_a_x,
	input  logic signed [COORD_WIDTH-1:0]     point_a_y,
	input  logic signed [COORD_WIDTH-1:0]     point_a_z,
	input  logic signed [COORD_WIDTH-1:0]     point_b_x,
	input  logic signed [COORD_WIDTH-1:0]     point_b_y,
	input  logic signed [COORD_WIDTH-1:0]     point_b_z,
	input  logic [COORD_WIDTH-2:0]            obj_radius,
	input  logic [COORD_WIDTH-2:0]            obj_distance,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [PIXEL_WIDTH-1:0]            size_px,
	output logic                              culled
);

	localparam int W     = COORD_WIDTH;
	localparam int PW    = W + 2;
	localparam int EW    = W + 1;
	localparam int MW    = W + 2;
	localparam int SQ1W  = 2 * MW;
	localparam int SQW   = 2 * W + 4;
	localparam int RTW   = W + 2;
	localparam int RW    = W + 1;
	localparam int DPW   = W + 18;
	localparam int DOTW  = W + 20;
	localparam int CMPW  = DOTW + 1;
	localparam int DDW   = W + 3;
	localparam int NUMW  = RW + SCALE_WIDTH;
	localparam int DENW  = W + 6;
	localparam int SIDEW = REQ_TYPE_WIDTH + 2 * (W - 1) + DOTW;
	localparam int DSW   = PIXEL_WIDTH + 3;

	logic signed [W-1:0]         cam_pos_q [3];
	logic signed [DIR_WIDTH-1:0] cam_dir_q [3];
	logic [SCALE_WIDTH-1:0]      view_h_q;

	logic en;
	logic buf_full;
	logic accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_q[0] <= '0;
			cam_pos_q[1] <= '0;
			cam_pos_q[2] <= '0;
			cam_dir_q[0] <= '0;
			cam_dir_q[1] <= '0;
			cam_dir_q[2] <= DIR_Z_RESET;
			view_h_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CAM_POS_X: cam_pos_q[0] <= cfg_data;
				CFG_CAM_POS_Y: cam_pos_q[1] <= cfg_data;
				CFG_CAM_POS_Z: cam_pos_q[2] <= cfg_data;
				CFG_CAM_DIR_X: cam_dir_q[0] <= cfg_data[DIR_WIDTH-1:0];
				CFG_CAM_DIR_Y: cam_dir_q[1] <= cfg_data[DIR_WIDTH-1:0];
				CFG_CAM_DIR_Z: cam_dir_q[2] <= cfg_data[DIR_WIDTH-1:0];
				CFG_VIEW_H:    view_h_q     <= cfg_data[SCALE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !buf_full;
	assign in_stall = buf_full;
	assign accept   = in_valid && en;

	// stage 1: offsets from the camera and box extent
	logic signed [W-1:0]  pa [3];
	logic signed [W-1:0]  pb [3];
	logic signed [PW-1:0] p_next [3];
	logic signed [EW-1:0] e_next [3];

	assign pa[0] = point_a_x;
	assign pa[1] = point_a_y;
	assign pa[2] = point_a_z;
	assign pb[0] = point_b_x;
	assign pb[1] = point_b_y;
	assign pb[2] = point_b_z;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (req_type == REQ_BOX) begin
				p_next[j] = PW'(pa[j]) + PW'(pb[j]) - (PW'(cam_pos_q[j]) <<< 1);
			end else begin
				p_next[j] = PW'(pa[j]) - PW'(cam_pos_q[j]);
			end
			e_next[j] = EW'(pb[j]) - EW'(pa[j]);
		end
	end

	logic                        vld_s1;
	logic [REQ_TYPE_WIDTH-1:0]   type_s1;
	logic signed [PW-1:0]        p_s1 [3];
	logic signed [EW-1:0]        e_s1 [3];
	logic [W-2:0]                r_s1;
	logic [W-2:0]                d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= req_type;
			p_s1    <= p_next;
			e_s1    <= e_next;
			r_s1    <= obj_radius;
			d_s1    <= obj_distance;
		end
	end

	// stage 2: magnitudes and direction products
	logic                        vld_s2;
	logic [REQ_TYPE_WIDTH-1:0]   type_s2;
	logic [MW-1:0]               mp_s2 [3];
	logic [MW-1:0]               me_s2 [3];
	logic signed [DPW-1:0]       dp_s2 [3];
	logic [W-2:0]                r_s2;
	logic [W-2:0]                d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				mp_s2[j] <= MW'(p_s1[j] < 0 ? -p_s1[j] : p_s1[j]);
				me_s2[j] <= MW'(e_s1[j] < 0 ? -e_s1[j] : e_s1[j]);
				dp_s2[j] <= DPW'(p_s1[j]) * DPW'(cam_dir_q[j]);
			end
			type_s2 <= type_s1;
			r_s2    <= r_s1;
			d_s2    <= d_s1;
		end
	end

	// stage 3: squares and dot product sum
	logic                        vld_s3;
	logic [REQ_TYPE_WIDTH-1:0]   type_s3;
	logic [SQ1W-1:0]             sp_s3 [3];
	logic [SQ1W-1:0]             se_s3 [3];
	logic signed [DOTW-1:0]      dot_s3;
	logic [W-2:0]                r_s3;
	logic [W-2:0]                d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				sp_s3[j] <= SQ1W'(mp_s2[j]) * SQ1W'(mp_s2[j]);
				se_s3[j] <= SQ1W'(me_s2[j]) * SQ1W'(me_s2[j]);
			end
			dot_s3  <= DOTW'(dp_s2[0]) + DOTW'(dp_s2[1]) + DOTW'(dp_s2[2]);
			type_s3 <= type_s2;
			r_s3    <= r_s2;
			d_s3    <= d_s2;
		end
	end

	// stage 4: sums of squares
	logic                        vld_s4;
	logic [SQW-1:0]              radp_s4;
	logic [SQW-1:0]              rade_s4;
	logic [SIDEW-1:0]            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			radp_s4 <= SQW'(sp_s3[0]) + SQW'(sp_s3[1]) + SQW'(sp_s3[2]);
			rade_s4 <= SQW'(se_s3[0]) + SQW'(se_s3[1]) + SQW'(se_s3[2]);
			side_s4 <= {type_s3, r_s3, d_s3, dot_s3};
		end
	end

	// square roots of the centre distance and the box diagonal
	logic                        sqp_valid;
	logic [SIDEW-1:0]            sqp_side;
	logic [RTW-1:0]              root_p;
	logic                        sqe_valid;
	logic [REQ_TYPE_WIDTH-1:0]   sqe_side;
	logic [RTW-1:0]              root_e;

	pps_sqrt #(.N(RTW), .SW(SIDEW)) u_sqrt_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.in_side  (side_s4),
		.radicand (radp_s4),
		.out_valid(sqp_valid),
		.out_side (sqp_side),
		.root     (root_p)
	);

	pps_sqrt #(.N(RTW), .SW(REQ_TYPE_WIDTH)) u_sqrt_diag (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.in_side  (side_s4[SIDEW-1 -: REQ_TYPE_WIDTH]),
		.radicand (rade_s4),
		.out_valid(sqe_valid),
		.out_side (sqe_side),
		.root     (root_e)
	);

	logic [REQ_TYPE_WIDTH-1:0]   sq_type;
	logic [W-2:0]                sq_r;
	logic [W-2:0]                sq_d;
	logic signed [DOTW-1:0]      sq_dot;

	assign {sq_type, sq_r, sq_d, sq_dot} = sqp_side;

	// stage 5: radius, distance, numerator, culling
	logic [RW-1:0]               rsel;
	logic signed [DDW-1:0]       d_next;
	logic signed [CMPW-1:0]      rshift;
	logic signed [CMPW-1:0]      cull_sum;

	always_comb begin
		rsel     = (sq_type == REQ_BOX) ? RW'(root_e) : RW'(sq_r);
		d_next   = (sq_type == REQ_RADIUS) ? DDW'(sq_d) : DDW'(root_p) - DDW'(rsel);
		rshift   = CMPW'(rsel) <<< DIR_FRAC;
		cull_sum = CMPW'(sq_dot) + rshift;
	end

	logic                        vld_s5;
	logic [REQ_TYPE_WIDTH-1:0]   type_s5;
	logic [RW-1:0]               r_s5;
	logic signed [DDW-1:0]       d_s5;
	logic [NUMW-1:0]             num_s5;
	logic                        cull_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= sqp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s5 <= sq_type;
			r_s5    <= rsel;
			d_s5    <= d_next;
			num_s5  <= NUMW'(rsel) * NUMW'(view_h_q);
			cull_s5 <= (sq_type == REQ_SPHERE || sq_type == REQ_BOX) && cull_sum < 0;
		end
	end

	// stage 6: near test and divider operands
	logic                        near;
	logic                        zero;
	logic                        bypass;
	logic signed [DDW:0]         d_cmp;
	logic signed [DDW:0]         r_cmp;

	always_comb begin
		r_cmp  = (DDW+1)'(r_s5);
		d_cmp  = (type_s5 == REQ_BOX) ? (DDW+1)'(d_s5) : (DDW+1)'(d_s5) <<< 1;
		near   = d_cmp <= r_cmp;
		zero   = cull_s5 || type_s5 == REQ_UNUSED;
		bypass = zero || near;
	end

	logic                        vld_s6;
	logic [NUMW-1:0]             num_s6;
	logic [DENW-1:0]             den_s6;
	logic [DSW-1:0]              dside_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6   <= bypass ? '0 : num_s5;
			den_s6   <= bypass ? DENW'(1) : DENW'(d_s5) << 4;
			dside_s6 <= {zero, near, cull_s5,
				(type_s5 == REQ_BOX) ? (view_h_q >> 4) : (view_h_q >> 3)};
		end
	end

	logic                        div_valid;
	logic [DSW-1:0]              div_side;
	logic [QUOT_WIDTH-1:0]       quot;

	pps_div #(.NW(NUMW), .DW(DENW), .QW(QUOT_WIDTH), .SW(DSW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s6),
		.in_side  (dside_s6),
		.num      (num_s6),
		.den      (den_s6),
		.out_valid(div_valid),
		.out_side (div_side),
		.quot     (quot)
	);

	logic                        f_zero;
	logic                        f_near;
	logic                        f_cull;
	logic [PIXEL_WIDTH-1:0]      f_fallback;
	pps_result_t                 result;
	pps_result_t                 out_data;

	assign {f_zero, f_near, f_cull, f_fallback} = div_side;

	always_comb begin
		priority if (f_zero) begin
			result.size_px = '0;
		end else if (f_near) begin
			result.size_px = f_fallback;
		end else begin
			result.size_px = PIXEL_WIDTH'(quot);
		end
		result.culled = f_cull;
	end

	pps_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (div_valid && en),
		.push_data(result),
		.full     (buf_full),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	assign size_px = out_data.size_px;
	assign culled  = out_data.culled;

	a_sqrt_align: assert property (@(posedge clk) disable iff (!arst_n)
		sqp_valid == sqe_valid && (!sqp_valid || sqe_side == sq_type))
		else $error("square root lanes out of step");
	a_cull_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && culled |-> size_px == '0)
		else $error("culled request with nonzero size");
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> size_px[PIXEL_WIDTH-1:QUOT_WIDTH] == '0)
		else $error("pixel size beyond reachable range");

endmodule
